@@ design/fp64_add_sub_mul_div_assert.svh @@
// assertion macros shared by the fp64 arithmetic block
`ifndef FP64_ADD_SUB_MUL_DIV_ASSERT_SVH
`define FP64_ADD_SUB_MUL_DIV_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPASMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FPASMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fpasmd_pkg.sv @@
package fpasmd_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;

  localparam int EXP_W = 14;
  localparam logic signed [EXP_W-1:0] EXP_UNB   = 14'sd1075;
  localparam logic signed [EXP_W-1:0] EXP_SUBN  = -14'sd1074;
  localparam logic signed [EXP_W-1:0] PACK_OFS  = 14'sd1085;
  localparam logic signed [EXP_W-1:0] EXP_MAXB  = 14'sd2047;
  localparam logic [5:0]              STEP_LAST = 6'd62;

  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_NORM, S_ALIGN, S_CMP, S_SUM, S_NORMS,
    S_MUL, S_MULF, S_DIV, S_DIVF, S_PACK, S_ROUND, S_DONE
  } state_t;

endpackage

@@ design/fpasmd_alu.sv @@
module fpasmd_alu
  import fpasmd_pkg::*;
(
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  alu_ctl_t    ctl,
  output logic [64:0] sum
);

  logic [63:0] b_in;

  // subtract as a plus inverted b plus carry in; carry out means no borrow
  assign b_in = ctl.sub ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_in} + {64'd0, ctl.cin};

endmodule

@@ design/fp64_add_sub_mul_div.sv @@
// channel  dir  tdata fields (low bit up)                       notes
// s_*      in   operation[1:0] a_bits[65:2] b_bits[129:66]      one request per op
// m_*      out  result_bits[63:0]                               one result per request
//
// sequence: a special operand is taken, loaded and its settled result posted;
// otherwise both operands are normalized, subnormal ones with more shift steps,
// then multiply and divide run 63 steps of the shared 64-bit adder plus 1 fixup,
// while add/subtract run align, compare, sum and a normalize shift loop; then pack
// and, where needed, round; the request port is ready only when the sequencer is
// idle, and a finished result sits in the output register while the next request
// is taken; rst is synchronous and clears the sequencer and the output valid
module fp64_add_sub_mul_div
  import fpasmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // operation, a_bits, b_bits, zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata    // result_bits
);

`include "fp64_add_sub_mul_div_assert.svh"

  state_t state, state_next;

  // request registers
  logic [1:0]  op;
  logic [63:0] abits, bbits;

  // working registers
  logic [62:0] fx, fy, gx, gy, lo;
  logic [63:0] acc;
  logic signed [EXP_W-1:0] xe, ye, ex;
  logic        sx, sy, sgn, sticky, swap, bw;
  logic [5:0]  cnt;
  logic [52:0] m;
  logic        rb, st, sub;
  logic [10:0] bexp;
  logic [63:0] res;

  // shared adder
  logic [63:0] alu_a, alu_b;
  alu_ctl_t    alu_ctl;
  logic [64:0] alu_sum;

  fpasmd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .ctl (alu_ctl),
    .sum (alu_sum)
  );

  // operand decode
  logic [10:0] ea, eb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb_eff, ng_md;
  logic special;
  logic [63:0] sres;

  assign ea     = abits[62:52];
  assign eb     = bbits[62:52];
  assign a_nan  = abits[62:0] > INF_MAG;
  assign b_nan  = bbits[62:0] > INF_MAG;
  assign a_inf  = abits[62:0] == INF_MAG;
  assign b_inf  = bbits[62:0] == INF_MAG;
  assign a_zero = abits[62:0] == 63'd0;
  assign b_zero = bbits[62:0] == 63'd0;
  assign sb_eff = bbits[63] ^ (op == OP_SUB);
  assign ng_md  = abits[63] ^ bbits[63];

  // special operands settle the result straight away
  always_comb begin
    special = 1'b1;
    sres    = QNAN;
    case (op)
      OP_ADD, OP_SUB: begin
        if (a_nan || b_nan) begin
          sres = QNAN;
        end else if (a_inf || b_inf) begin
          if (a_inf && b_inf && (abits[63] != sb_eff)) sres = QNAN;
          else sres = {a_inf ? abits[63] : sb_eff, INF_MAG};
        end else if (a_zero && b_zero) begin
          sres = {abits[63] & sb_eff, 63'd0};
        end else if (a_zero) begin
          sres = {sb_eff, bbits[62:0]};
        end else if (b_zero) begin
          sres = abits;
        end else begin
          special = 1'b0;
        end
      end
      OP_MUL: begin
        if (a_nan || b_nan) sres = QNAN;
        else if (a_inf || b_inf) sres = (a_zero || b_zero) ? QNAN : {ng_md, INF_MAG};
        else if (a_zero || b_zero) sres = {ng_md, 63'd0};
        else special = 1'b0;
      end
      default: begin
        if (a_nan || b_nan) sres = QNAN;
        else if (a_inf && b_inf) sres = QNAN;
        else if (a_inf) sres = {ng_md, INF_MAG};
        else if (b_inf) sres = {ng_md, 63'd0};
        else if (b_zero) sres = a_zero ? QNAN : {ng_md, INF_MAG};
        else if (a_zero) sres = {ng_md, 63'd0};
        else special = 1'b0;
      end
    endcase
  end

  logic norm_done;
  assign norm_done = fx[62] && fy[62];

  // alignment
  logic signed [EXP_W-1:0] d, dm;
  logic        dge, dbig;
  logic [62:0] smaller, shifted, lost, amask;
  assign d       = xe - ye;
  assign dge     = d >= 0;
  assign dm      = dge ? d : -d;
  assign dbig    = dm >= 14'sd64;
  assign smaller = dge ? fy : fx;
  assign amask   = (63'd1 << dm[5:0]) - 63'd1;
  assign shifted = dbig ? 63'd0 : (smaller >> dm[5:0]);
  assign lost    = dbig ? smaller : (smaller & amask);

  // magnitude compare for effective subtraction
  logic x_wins;
  assign x_wins = (alu_sum[64] && (alu_sum[63:0] != 64'd0)) ||
                  ((alu_sum[63:0] == 64'd0) && (gx >= gy));

  // divide step
  logic [63:0] part_n;
  assign part_n = alu_sum[64] ? alu_sum[63:0] : acc;

  // packing
  logic signed [EXP_W-1:0] biased, sh;
  logic [5:0]  sh6, sh1;
  logic [62:0] lmask, fr_sh;
  assign biased = ex + PACK_OFS;
  assign sh     = 14'sd11 - biased;
  assign sh6    = sh[5:0];
  assign sh1    = sh6 - 6'd1;
  assign lmask  = (63'd1 << sh1) - 63'd1;
  assign fr_sh  = acc[62:0] >> sh6;

  // rounding
  logic        inc;
  logic [53:0] m2;
  logic [11:0] b1;
  assign inc = rb & (st | m[0]);
  assign m2  = {1'b0, m} + {53'd0, inc};
  assign b1  = {1'b0, bexp} + 12'd1;

  logic load_out;
  assign load_out = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_LOAD;
      S_LOAD:  state_next = special ? S_DONE : S_NORM;
      S_NORM: begin
        if (norm_done) begin
          case (op)
            OP_MUL:  state_next = S_MUL;
            OP_DIV:  state_next = S_DIV;
            default: state_next = S_ALIGN;
          endcase
        end
      end
      S_ALIGN: state_next = S_CMP;
      S_CMP:   state_next = S_SUM;
      S_SUM: begin
        if (sx == sy) state_next = S_PACK;
        else if (alu_sum[62:0] == 63'd0 && !sticky) state_next = S_DONE;
        else state_next = S_NORMS;
      end
      S_NORMS: if (acc[62] || acc[61:0] == 62'd0) state_next = S_PACK;
      S_MUL:   if (cnt == 6'd0) state_next = S_MULF;
      S_MULF:  state_next = S_PACK;
      S_DIV:   if (cnt == 6'd0) state_next = S_DIVF;
      S_DIVF:  state_next = S_PACK;
      S_PACK: begin
        if (biased >= EXP_MAXB) state_next = S_DONE;
        else if (biased <= 0 && sh >= 14'sd64) state_next = S_DONE;
        else state_next = S_ROUND;
      end
      S_ROUND: state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and adder operand selection
  always_comb begin
    s_tready = (state == S_IDLE);
    alu_a    = {1'b0, fx};
    alu_b    = {1'b0, fy};
    alu_ctl  = '{sub: 1'b1, cin: 1'b1};
    case (state)
      S_SUM: begin
        if (sx == sy) begin
          alu_ctl = '{sub: 1'b0, cin: 1'b0};
        end else begin
          alu_a   = {1'b0, swap ? fy : fx};
          alu_b   = {1'b0, swap ? fx : fy};
          alu_ctl = '{sub: 1'b1, cin: !bw};
        end
      end
      S_MUL: begin
        alu_a   = {1'b0, acc[62:0]};
        alu_b   = lo[0] ? {1'b0, fx} : 64'd0;
        alu_ctl = '{sub: 1'b0, cin: 1'b0};
      end
      S_DIV: begin
        alu_a = acc;
        alu_b = {1'b0, fy};
      end
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && load_out) m_tdata <= res;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op    <= s_tdata[1:0];
          abits <= s_tdata[65:2];
          bbits <= s_tdata[129:66];
        end
      end
      S_LOAD: begin
        res <= sres;
        fx  <= {10'd0, |ea, abits[51:0]};
        fy  <= {10'd0, |eb, bbits[51:0]};
        xe  <= (|ea) ? $signed({3'b000, ea}) - EXP_UNB : EXP_SUBN;
        ye  <= (|eb) ? $signed({3'b000, eb}) - EXP_UNB : EXP_SUBN;
        sx  <= abits[63];
        sy  <= (op == OP_MUL || op == OP_DIV) ? bbits[63] : sb_eff;
        sgn <= ng_md;
      end
      S_NORM: begin
        if (!fx[62]) begin
          fx <= {fx[61:0], 1'b0};
          xe <= xe - 14'sd1;
        end
        if (!fy[62]) begin
          fy <= {fy[61:0], 1'b0};
          ye <= ye - 14'sd1;
        end
        cnt <= STEP_LAST;
        if (op == OP_DIV) begin
          acc <= {1'b0, fx};
          lo  <= 63'd0;
        end else begin
          acc <= 64'd0;
          lo  <= fy;
        end
      end
      S_ALIGN: begin
        ex     <= dge ? xe : ye;
        sticky <= |lost;
        if (dge) begin
          fy <= shifted;
          gy <= lost;
          gx <= 63'd0;
        end else begin
          fx <= shifted;
          gx <= lost;
          gy <= 63'd0;
        end
      end
      S_CMP: begin
        swap <= !x_wins;
        bw   <= x_wins ? (gy > gx) : (gx > gy);
        sgn  <= (sx == sy) ? sx : (x_wins ? sx : sy);
      end
      S_SUM: begin
        if (sx == sy) begin
          if (alu_sum[63]) begin
            acc    <= {1'b0, alu_sum[63:1]};
            sticky <= sticky | alu_sum[0];
            ex     <= ex + 14'sd1;
          end else begin
            acc <= alu_sum[63:0];
          end
        end else begin
          acc <= {1'b0, alu_sum[62:0]};
          res <= 64'd0;   // exact cancellation
        end
      end
      S_NORMS: begin
        if (!acc[62]) begin
          acc <= {1'b0, acc[61:0], 1'b0};
          ex  <= ex - 14'sd1;
        end
      end
      S_MUL: begin
        acc <= {1'b0, alu_sum[63:1]};
        lo  <= {alu_sum[0], lo[62:1]};
        cnt <= cnt - 6'd1;
      end
      S_MULF: begin
        if (acc[62]) begin
          sticky <= |lo;
          ex     <= xe + ye + 14'sd63;
        end else begin
          acc    <= {1'b0, acc[61:0], lo[62]};
          sticky <= |lo[61:0];
          ex     <= xe + ye + 14'sd62;
        end
      end
      S_DIV: begin
        acc <= {part_n[62:0], 1'b0};
        lo  <= {lo[61:0], alu_sum[64]};
        cnt <= cnt - 6'd1;
      end
      S_DIVF: begin
        sticky <= acc != 64'd0;
        if (!lo[62]) begin
          acc <= {1'b0, lo[61:0], 1'b0};
          ex  <= xe - ye - 14'sd63;
        end else begin
          acc <= {1'b0, lo};
          ex  <= xe - ye - 14'sd62;
        end
      end
      S_PACK: begin
        bexp <= biased[10:0];
        if (biased >= EXP_MAXB) begin
          res <= {sgn, INF_MAG};
        end else if (biased <= 0) begin
          res <= {sgn, 63'd0};
          m   <= fr_sh[52:0];
          rb  <= acc[sh1];
          st  <= (|(acc[62:0] & lmask)) | sticky;
          sub <= 1'b1;
        end else begin
          m   <= acc[62:10];
          rb  <= acc[9];
          st  <= (|acc[8:0]) | sticky;
          sub <= 1'b0;
        end
      end
      S_ROUND: begin
        if (sub) res <= {sgn, 10'd0, m2[52:0]};
        else if (m2[53]) res <= (b1 >= 12'd2047) ? {sgn, INF_MAG} : {sgn, b1[10:0], m2[52:1]};
        else res <= {sgn, bexp, m2[51:0]};
      end
      default: ;
    endcase
  end

  `FPASMD_ASSERT_NEXT(a_req_load, s_tvalid && s_tready, state == S_LOAD, "request not loaded")
  `FPASMD_ASSERT_NEXT(a_done_out, state == S_DONE && load_out, m_tvalid && state == S_IDLE, "result not posted")
  `FPASMD_ASSERT_NEXT(a_mul_loop, state == S_MUL, state == S_MUL || state == S_MULF, "multiply loop left early")

endmodule

@@ dv/fp64_add_sub_mul_div_checker.sv @@
`timescale 1ns / 100ps
module fp64_add_sub_mul_div_checker
  import fpasmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic        neg;
    int          ex;
    logic [63:0] fr;
    int          kind;  // 0 finite, 1 zero, 2 inf, 3 nan
  } unpacked_t;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FRAC_M   = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIDDEN   = 64'h0010_0000_0000_0000;

  logic [63:0] expected_results[$];
  logic [1:0]  expected_ops[$];
  int          results_seen;

  function automatic unpacked_t unpack_fp(logic [63:0] w);
    unpacked_t p;
    int e;
    e = int'(w[62:52]);
    p.neg = w[63];
    p.ex = 0;
    p.fr = '0;
    if (e == 2047) begin
      p.kind = (w[51:0] != 0) ? 3 : 2;
      return p;
    end
    if (e == 0 && w[51:0] == 0) begin
      p.kind = 1;
      return p;
    end
    p.kind = 0;
    if (e == 0) begin
      p.fr = w & FRAC_M;
      p.ex = 1 - 1023 - 52;
    end else begin
      p.fr = (w & FRAC_M) | HIDDEN;
      p.ex = e - 1023 - 52;
    end
    while (!p.fr[62]) begin
      p.fr = p.fr << 1;
      p.ex--;
    end
    return p;
  endfunction

  // single rounding to nearest even, normal and subnormal ranges
  function automatic logic [63:0] pack_rounded(logic neg, int ex, logic [63:0] fr,
                                               logic extra);
    logic [63:0] sgn, m;
    logic        rb, st;
    int          biased, sh;
    sgn = {neg, 63'd0};
    biased = ex + 62 + 1023;
    if (biased >= 2047) return sgn | INF_BITS;
    if (biased <= 0) begin
      sh = -(ex + 1074);
      if (sh >= 64) return sgn;
      if (sh <= 0) begin
        m = fr;
        rb = 1'b0;
        st = extra;
      end else begin
        m = fr >> sh;
        rb = fr[sh-1];
        st = ((fr & ((64'd1 << (sh - 1)) - 1)) != 0) || extra;
      end
      if (rb && (st || m[0])) m++;
      return sgn | (m & (FRAC_M | HIDDEN));
    end
    m = fr >> 10;
    rb = fr[9];
    st = (fr[8:0] != 0) || extra;
    if (rb && (st || m[0])) m++;
    if (m[53]) begin
      m = m >> 1;
      biased++;
      if (biased >= 2047) return sgn | INF_BITS;
    end
    return sgn | (64'(biased) << 52) | (m & FRAC_M);
  endfunction

  function automatic logic is_nan(logic [63:0] w);
    return w[62:0] > INF_BITS[62:0];
  endfunction

  function automatic logic [63:0] add_sub_result(logic [63:0] wa, logic [63:0] wb,
                                                 logic negb);
    unpacked_t x, y;
    logic [63:0] gx, gy, lost, acc;
    int ex, d;
    logic ng;
    gx = '0;
    gy = '0;
    if (is_nan(wa) || is_nan(wb)) return QNAN;
    x = unpack_fp(wa);
    y = unpack_fp(wb);
    if (negb) y.neg = ~y.neg;
    if (x.kind == 2 || y.kind == 2) begin
      if (x.kind == 2 && y.kind == 2 && x.neg != y.neg) return QNAN;
      ng = (x.kind == 2) ? x.neg : y.neg;
      return {ng, 63'd0} | INF_BITS;
    end
    if (x.kind == 1 && y.kind == 1) return (x.neg && y.neg) ? SIGN_BIT : 64'd0;
    if (x.kind == 1) return wb ^ (negb ? SIGN_BIT : 64'd0);
    if (y.kind == 1) return wa;
    if (x.ex >= y.ex) begin
      d = x.ex - y.ex;
      ex = x.ex;
      if (d >= 64) begin
        gy = y.fr;
        y.fr = '0;
      end else if (d > 0) begin
        gy = y.fr & ((64'd1 << d) - 1);
        y.fr = y.fr >> d;
      end
    end else begin
      d = y.ex - x.ex;
      ex = y.ex;
      if (d >= 64) begin
        gx = x.fr;
        x.fr = '0;
      end else begin
        gx = x.fr & ((64'd1 << d) - 1);
        x.fr = x.fr >> d;
      end
    end
    lost = gx | gy;
    if (x.neg == y.neg) begin
      acc = x.fr + y.fr;
      ng = x.neg;
      if (acc[63]) begin
        lost = lost | {63'd0, acc[0]};
        acc = acc >> 1;
        ex++;
      end
    end else begin
      // borrow approximation when alignment shifted bits out
      if (x.fr > y.fr || (x.fr == y.fr && gx >= gy)) begin
        acc = x.fr - y.fr - ((gy > gx) ? 64'd1 : 64'd0);
        ng = x.neg;
      end else begin
        acc = y.fr - x.fr - ((gx > gy) ? 64'd1 : 64'd0);
        ng = y.neg;
      end
      if (acc == 0 && lost == 0) return 64'd0;
      while (!acc[62]) begin
        acc = acc << 1;
        ex--;
        if (acc == 0) break;
      end
    end
    return pack_rounded(ng, ex, acc, lost != 0);
  endfunction

  function automatic logic [63:0] product_result(logic [63:0] wa, logic [63:0] wb);
    unpacked_t x, y;
    logic [127:0] prod;
    logic [63:0]  fr;
    logic         ng, lost;
    int           ex;
    if (is_nan(wa) || is_nan(wb)) return QNAN;
    x = unpack_fp(wa);
    y = unpack_fp(wb);
    ng = x.neg ^ y.neg;
    if (x.kind == 2 || y.kind == 2) begin
      if (x.kind == 1 || y.kind == 1) return QNAN;
      return {ng, 63'd0} | INF_BITS;
    end
    if (x.kind == 1 || y.kind == 1) return {ng, 63'd0};
    prod = x.fr * y.fr;
    if (prod[125]) begin
      fr = prod[126:63];
      lost = prod[62:0] != 0;
      ex = x.ex + y.ex + 63;
    end else begin
      fr = prod[125:62];
      lost = prod[61:0] != 0;
      ex = x.ex + y.ex + 62;
    end
    return pack_rounded(ng, ex, fr, lost);
  endfunction

  function automatic logic [63:0] quotient_result(logic [63:0] wa, logic [63:0] wb);
    unpacked_t x, y;
    logic [63:0] rem, quo;
    logic        ng;
    int          adj;
    if (is_nan(wa) || is_nan(wb)) return QNAN;
    x = unpack_fp(wa);
    y = unpack_fp(wb);
    ng = x.neg ^ y.neg;
    adj = 0;
    quo = '0;
    if (x.kind == 2 && y.kind == 2) return QNAN;
    if (x.kind == 2) return {ng, 63'd0} | INF_BITS;
    if (y.kind == 2) return {ng, 63'd0};
    if (y.kind == 1) begin
      if (x.kind == 1) return QNAN;
      return {ng, 63'd0} | INF_BITS;
    end
    if (x.kind == 1) return {ng, 63'd0};
    rem = x.fr;
    for (int k = 62; k >= 0; k--) begin
      if (rem >= y.fr) begin
        quo[k] = 1'b1;
        rem = rem - y.fr;
      end
      rem = rem << 1;
    end
    if (!quo[62]) begin
      quo = quo << 1;
      adj = 1;
    end
    return pack_rounded(ng, x.ex - y.ex - adj - 62, quo, rem != 0);
  endfunction

  function automatic logic [63:0] fp_result(logic [1:0] op, logic [63:0] a,
                                            logic [63:0] b);
    case (op)
      OP_ADD:  return add_sub_result(a, b, 1'b0);
      OP_SUB:  return add_sub_result(a, b, 1'b1);
      OP_MUL:  return product_result(a, b);
      default: return quotient_result(a, b);
    endcase
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(fp_result(s_tdata[1:0], s_tdata[65:2],
                                             s_tdata[129:66]));
        expected_ops.push_back(s_tdata[1:0]);
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("result %h with no request outstanding", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (m_tdata !== expected_results[0]) begin
            if (fail_count < 10)
              $display("mismatch op %0d result %0d: expected %h got %h",
                       expected_ops[0], results_seen, expected_results[0], m_tdata);
            fail_count <= fail_count + 1;
          end
          void'(expected_results.pop_front());
          void'(expected_ops.pop_front());
        end
      end
    end
  end

endmodule

@@ dv/fp64_add_sub_mul_div_tb.sv @@
`timescale 1ns / 100ps
module fp64_add_sub_mul_div_tb
  import fpasmd_pkg::*;
();

  localparam int  RANDOM_REQUESTS = 880;
  localparam int  CYCLE_LIMIT     = 600000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  int           fail_count;
  int           pending;
  int           cycles;
  int           requests_sent;
  logic         hold_off_active;
  logic         stimulus_done;

  fp64_add_sub_mul_div dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fp64_add_sub_mul_div_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // interesting operand patterns: zeros, subnormal edges, normal edges, inf, nans
  function automatic logic [63:0] corner_operand();
    logic [63:0] v;
    case ($urandom_range(0, 13))
      0:  v = 64'h0;
      1:  v = 64'h0000_0000_0000_0001;
      2:  v = 64'h000F_FFFF_FFFF_FFFF;
      3:  v = 64'h0010_0000_0000_0000;
      4:  v = 64'h7FEF_FFFF_FFFF_FFFF;
      5:  v = 64'h7FF0_0000_0000_0000;
      6:  v = 64'h7FF8_0000_0000_0000;
      7:  v = 64'h7FF0_0000_0000_0001;
      8:  v = 64'h3FF0_0000_0000_0000;
      9:  v = {12'h000, 20'($urandom), 32'($urandom)};
      10: v = {1'b0, 11'($urandom_range(1000, 1046)), 20'($urandom), 32'($urandom)};
      11: v = 64'h3FF0_0000_0000_0000 | 64'($urandom_range(0, 3));
      12: v = {1'b0, 11'($urandom_range(1, 60)), 20'($urandom), 32'($urandom)};
      default: v = {1'b0, 11'($urandom_range(1990, 2046)), 20'($urandom), 32'($urandom)};
    endcase
    v[63] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic logic [63:0] random_operand();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return corner_operand();
      default:  // mid-range values so sums and quotients stay finite
        return {1'(($urandom_range(0, 1))), 11'($urandom_range(990, 1060)),
                20'($urandom), 32'($urandom)};
    endcase
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [1:0] op, logic [63:0] a, logic [63:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stall pattern, with one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_active) begin
      m_tready <= 1'b0;
    end else if (stimulus_done) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      case ((cycles / 2000) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    hold_off_active = 1'b0;
    wait (requests_sent >= 40);
    @(posedge clk);
    hold_off_active <= 1'b1;
    repeat (800) @(posedge clk);
    hold_off_active <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int burst;
    int drain;
    cycles = 0;
    requests_sent = 0;
    stimulus_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: special cases per operation
    send_request(OP_ADD, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);  // inf - inf
    send_request(OP_SUB, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    send_request(OP_MUL, 64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000);  // inf * 0
    send_request(OP_DIV, 64'h0, 64'h8000_0000_0000_0000);                    // 0 / 0
    send_request(OP_DIV, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);  // inf / inf
    send_request(OP_DIV, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);  // x / inf
    send_request(OP_DIV, 64'hC000_0000_0000_0000, 64'h0);                    // divide by zero
    send_request(OP_ADD, 64'hFFF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);  // nan payload
    send_request(OP_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);  // -0 + -0
    send_request(OP_SUB, 64'h8000_0000_0000_0000, 64'h0);                    // -0 - +0
    send_request(OP_SUB, 64'h0, 64'h4008_0000_0000_0000);                    // zero passthrough
    send_request(OP_ADD, 64'hC008_0000_0000_0000, 64'h0);
    send_request(OP_SUB, 64'h4008_0000_0000_0000, 64'h4008_0000_0000_0000);  // exact cancel
    send_request(OP_SUB, 64'h3FF0_0000_0000_0000, 64'h3C90_0000_0000_0001);  // borrow
    send_request(OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);  // overflow
    send_request(OP_MUL, 64'hFFEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000);
    send_request(OP_MUL, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000);  // underflow tie
    send_request(OP_MUL, 64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001);  // to min normal
    send_request(OP_DIV, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF);
    send_request(OP_DIV, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    send_request(OP_ADD, 64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    send_request(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_MUL, 64'h3FF0_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF);
    gap(1);

    // sender pause until everything has come back
    while (pending != 0) @(posedge clk);

    // random bursts with gaps
    while (requests_sent < RANDOM_REQUESTS + 23) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++)
        send_request(2'($urandom_range(0, 3)), random_operand(), random_operand());
      gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90));
    end
    s_tvalid <= 1'b0;
    stimulus_done = 1'b1;

    while (pending != 0) @(posedge clk);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk);
      drain++;
    end
    $display("sent %0d requests over add, subtract, multiply and divide,", requests_sent);
    $display("including specials, subnormals, overflow and long output stalls");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
